// ----- rtl/core/imufp_pkg.sv -----
package imufp_pkg;

    localparam logic [7:0] HDR_BYTE = 8'hAA;
    localparam int         FILL_W   = 5;

    // byte positions within the 19-byte frame
    localparam logic [FILL_W-1:0] POS_FIRST     = 5'd2;
    localparam logic [FILL_W-1:0] POS_STORE_END = 5'd14;
    localparam logic [FILL_W-1:0] POS_LAST      = 5'd18;
    localparam int                STORE_N       = 13;
    localparam int                STORE_IDX_W   = 4;

    localparam int OUT_W       = 171;
    localparam int OUT_TDATA_W = 176;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ROLL_OFFSET  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_OFFSET = 1'b1;

    typedef enum logic [2:0] {
        ST_HUNT = 3'b001,
        ST_HDR1 = 3'b010,
        ST_FILL = 3'b100
    } t_hunt;

    typedef struct packed {
        logic        ok;
        logic [7:0]  index;
        logic [15:0] yaw;
        logic [15:0] pitch;
        logic [15:0] roll;
        logic [15:0] accel_x;
        logic [15:0] accel_y;
        logic [15:0] accel_z;
        logic [31:0] good;
        logic [31:0] bad;
    } t_frame;

    typedef struct packed {
        logic [31:0]        bad_frames;
        logic [31:0]        good_frames;
        logic signed [15:0] accel_z;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_x;
        logic signed [16:0] roll_angle;
        logic signed [16:0] pitch_angle;
        logic signed [15:0] yaw_angle;
        logic [7:0]         frame_index;
        logic               checksum_good;
    } t_result;

endpackage

// ----- rtl/core/imufp_framer.sv -----
module imufp_framer #(
    parameter int COUNTER_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_byte,
    output logic                o_evt_valid,
    output imufp_pkg::t_frame   o_frame
);

    imufp_pkg::t_hunt                  r_hunt, n_hunt;
    logic [imufp_pkg::FILL_W-1:0]      r_fill, n_fill;
    logic [7:0]                        r_sum, n_sum;
    logic [7:0]                        r_store [imufp_pkg::STORE_N];
    logic [COUNTER_BITS-1:0]           r_good, n_good;
    logic [COUNTER_BITS-1:0]           r_bad, n_bad;
    logic                              r_evt_valid, n_evt_valid;
    logic                              r_evt_ok, n_evt_ok;
    logic                              store_we;
    logic [imufp_pkg::STORE_IDX_W-1:0] store_idx;

    assign store_idx = imufp_pkg::STORE_IDX_W'(r_fill - imufp_pkg::POS_FIRST);
    assign store_we  = i_valid && (r_hunt == imufp_pkg::ST_FILL)
                       && (r_fill <= imufp_pkg::POS_STORE_END);

    always_comb begin
        n_hunt      = r_hunt;
        n_fill      = r_fill;
        n_sum       = r_sum;
        n_good      = r_good;
        n_bad       = r_bad;
        n_evt_valid = 1'b0;
        n_evt_ok    = r_evt_ok;
        if (i_valid) begin
            unique case (r_hunt)
                imufp_pkg::ST_HUNT: begin
                    if (i_byte == imufp_pkg::HDR_BYTE) begin
                        n_hunt = imufp_pkg::ST_HDR1;
                    end
                end
                imufp_pkg::ST_HDR1: begin
                    if (i_byte == imufp_pkg::HDR_BYTE) begin
                        n_hunt = imufp_pkg::ST_FILL;
                        n_fill = imufp_pkg::POS_FIRST;
                        n_sum  = '0;
                    end else begin
                        n_hunt = imufp_pkg::ST_HUNT;
                    end
                end
                imufp_pkg::ST_FILL: begin
                    if (r_fill == imufp_pkg::POS_LAST) begin
                        n_hunt      = imufp_pkg::ST_HUNT;
                        n_fill      = '0;
                        n_evt_valid = 1'b1;
                        n_evt_ok    = (r_sum == i_byte);
                        if (r_sum == i_byte) begin
                            n_good = r_good + 1'b1;
                        end else begin
                            n_bad = r_bad + 1'b1;
                        end
                    end else begin
                        n_fill = r_fill + 1'b1;
                        n_sum  = r_sum + i_byte;
                    end
                end
                default: begin
                    n_hunt = imufp_pkg::ST_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hunt      <= imufp_pkg::ST_HUNT;
            r_fill      <= '0;
            r_sum       <= '0;
            r_good      <= '0;
            r_bad       <= '0;
            r_evt_valid <= 1'b0;
            r_evt_ok    <= 1'b0;
        end else begin
            r_hunt      <= n_hunt;
            r_fill      <= n_fill;
            r_sum       <= n_sum;
            r_good      <= n_good;
            r_bad       <= n_bad;
            r_evt_valid <= n_evt_valid;
            r_evt_ok    <= n_evt_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[store_idx] <= i_byte;
        end
    end

    // store slot k holds frame byte k+2
    assign o_evt_valid     = r_evt_valid;
    assign o_frame.ok      = r_evt_ok;
    assign o_frame.index   = r_store[0];
    assign o_frame.yaw     = {r_store[2],  r_store[1]};
    assign o_frame.pitch   = {r_store[4],  r_store[3]};
    assign o_frame.roll    = {r_store[6],  r_store[5]};
    assign o_frame.accel_x = {r_store[8],  r_store[7]};
    assign o_frame.accel_y = {r_store[10], r_store[9]};
    assign o_frame.accel_z = {r_store[12], r_store[11]};
    assign o_frame.good    = 32'(r_good);
    assign o_frame.bad     = 32'(r_bad);

endmodule

// ----- rtl/core/imufp_decode.sv -----
module imufp_decode (
    input  imufp_pkg::t_frame                    i_frame,
    input  logic [imufp_pkg::CFG_DATA_W-1:0]     i_roll_offset,
    input  logic [imufp_pkg::CFG_DATA_W-1:0]     i_pitch_offset,
    output imufp_pkg::t_result                   o_result
);

    logic signed [16:0] pitch_diff;
    logic signed [16:0] roll_diff;

    assign pitch_diff = $signed({i_frame.pitch[15], i_frame.pitch})
                        - $signed({i_pitch_offset[15], i_pitch_offset});
    assign roll_diff  = $signed({i_frame.roll[15], i_frame.roll})
                        - $signed({i_roll_offset[15], i_roll_offset});

    always_comb begin
        o_result               = '0;
        o_result.good_frames   = i_frame.good;
        o_result.bad_frames    = i_frame.bad;
        if (i_frame.ok) begin
            o_result.checksum_good = 1'b1;
            o_result.frame_index   = i_frame.index;
            o_result.yaw_angle     = $signed(i_frame.yaw);
            o_result.pitch_angle   = pitch_diff;
            o_result.roll_angle    = roll_diff;
            o_result.accel_x       = $signed(i_frame.accel_x);
            o_result.accel_y       = $signed(i_frame.accel_y);
            o_result.accel_z       = $signed(i_frame.accel_z);
        end
    end

endmodule

// ----- rtl/core/imufp_obuf.sv -----
module imufp_obuf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  imufp_pkg::t_result   i_data,
    output logic                 o_full,
    output logic                 o_valid,
    input  logic                 i_ready,
    output imufp_pkg::t_result   o_data
);

    logic               r_out_valid, r_skid_valid;
    imufp_pkg::t_result r_out, r_skid;
    logic               take;

    assign take = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= i_valid;
            end else begin
                r_out_valid  <= i_valid;
            end
        end else if (i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            if (r_skid_valid) begin
                r_out  <= r_skid;
                r_skid <= i_data;
            end else begin
                r_out  <= i_data;
            end
        end else if (i_valid) begin
            r_skid <= i_data;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ----- rtl/core/imu_uart_frame_parser_unit.sv -----
// Serial IMU frame parser.
// Slave stream: one received byte per word on i_s_tdata. Master stream: one
// word per completed 19-byte frame (two 0xAA header bytes, index, six int16
// little-endian values, three reserved bytes, 8-bit sum of bytes 2..17).
// A bad sum gives a word with checksum_good low and zero data fields; the
// good/bad frame counts are always valid.
// Config: i_cfg_we writes i_cfg_data to register i_cfg_idx (0 roll offset,
// 1 pitch offset), each subtracted from the matching decoded angle.
// Throughput: one byte per cycle while o_s_tready is high. The result word
// reaches the master side through the framer event register, then the
// output register.
// Reset (synchronous, active low) returns to header hunting, clears both
// counters and both offsets, and empties the output buffer.
// When the receiver stalls, a result waits in the output register and a
// second one may be held in the skid stage; bytes keep flowing until the
// skid stage is occupied, then o_s_tready drops.
module imu_uart_frame_parser_unit #(
    parameter int COUNTER_BITS = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [7:0]                            i_s_tdata,  // [7:0] rx_byte
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // [0] checksum_good, [8:1] frame_index, [24:9] yaw_angle,
    // [41:25] pitch_angle, [58:42] roll_angle, [74:59] accel_x,
    // [90:75] accel_y, [106:91] accel_z, [138:107] good_frames,
    // [170:139] bad_frames, [175:171] zero
    output logic [imufp_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    input  logic                                  i_cfg_we,
    input  logic [imufp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [imufp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic [imufp_pkg::CFG_DATA_W-1:0] r_roll_off, r_pitch_off;
    logic                             in_accept;
    logic                             evt_valid;
    logic                             buf_full;
    imufp_pkg::t_frame                frame;
    imufp_pkg::t_result               result;
    imufp_pkg::t_result               out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roll_off  <= '0;
            r_pitch_off <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                imufp_pkg::CFG_ROLL_OFFSET:  r_roll_off  <= i_cfg_data;
                imufp_pkg::CFG_PITCH_OFFSET: r_pitch_off <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_s_tready = !buf_full;
    assign in_accept  = i_s_tvalid && !buf_full;

    imufp_framer #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_framer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_accept),
        .i_byte      (i_s_tdata),
        .o_evt_valid (evt_valid),
        .o_frame     (frame)
    );

    imufp_decode u_decode (
        .i_frame        (frame),
        .i_roll_offset  (r_roll_off),
        .i_pitch_offset (r_pitch_off),
        .o_result       (result)
    );

    imufp_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (evt_valid),
        .i_data  (result),
        .o_full  (buf_full),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (out_word)
    );

    assign o_m_tdata = {
        {(imufp_pkg::OUT_TDATA_W - imufp_pkg::OUT_W){1'b0}},
        out_word
    };

endmodule
